// File: rtl/core/psla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psla_pkg
// Shared types, sizes and helpers for the persistent stack level ancestor unit.
// ----------------------------------------------------------------------------
package psla_pkg;

  // Store geometry
  localparam int NODES      = 1024;
  localparam int LEVELS     = 10;
  localparam int VALUE_BITS = 8;

  // Fixed field widths of the transaction ports
  localparam int CMD_W     = 2;
  localparam int VERSION_W = 10;
  localparam int PVAL_W    = 8;
  localparam int KBITS     = 10;
  localparam int DEPTH_W   = 10;
  localparam int STATUS_W  = 2;

  // Derived widths
  localparam int NODE_W = (NODES > 2) ? $clog2(NODES) : 1;
  localparam int NF_W   = $clog2(NODES + 1);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVC_W  = $clog2(LEVELS + 1);
  localparam int KB_W   = $clog2(KBITS + 1);
  localparam int KI_W   = (KBITS > 1) ? $clog2(KBITS) : 1;
  localparam int REP_W  = KBITS;
  localparam int CMP_W  = (KBITS > NODE_W) ? KBITS : NODE_W;
  localparam int JT_AW  = NODE_W + LVL_W;
  localparam int JT_DEPTH = NODES << LVL_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_TOP  = 2'd2,
    CMD_KTH  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_KBIG  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RES_FULL,
    RES_EMPTY,
    RES_POP,
    RES_TOP,
    RES_KBIG,
    RES_PUSH,
    RES_KTH
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_LINK,
    S_LINK_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_VALUE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     rd_node;
    logic     chk;
    logic     push_start;
    logic     link_zero;
    logic     link_rd;
    logic     link_wr;
    logic     walk_start;
    logic     walk_skip;
    logic     walk_rd;
    logic     walk_step;
    logic     val_rd;
    logic     res_load;
    res_sel_t res_sel;
  } psla_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t command;
    logic full;
    logic depth_zero;
    logic k_big;
    logic link_done;
    logic mid_zero;
    logic bit_end;
    logic bit_set;
  } psla_stat_t;

  // Number of jumps at level walk_level(b) that one set bit of k stands for
  function automatic logic [REP_W-1:0] rep_of(input logic [KB_W-1:0] b);
    logic [REP_W-1:0] r;
    r = REP_W'(1);
    if (int'(b) >= LEVELS) begin
      r = REP_W'(1) << (int'(b) - LEVELS + 1);
    end
    return r;
  endfunction

  // Jump level used for bit b of k
  function automatic logic [LVL_W-1:0] walk_level(input logic [KB_W-1:0] b);
    logic [LVL_W-1:0] l;
    l = LVL_W'(LEVELS - 1);
    if (int'(b) < LEVELS) begin
      l = LVL_W'(b);
    end
    return l;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/persistent_stack_level_ancestor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// persistent_stack_level_ancestor_unit
// Persistent stack with level-ancestor queries by binary lifting.
// ----------------------------------------------------------------------------
// Pop and top load the result register in the check state that follows the
// node read; push instead builds its jump links level by level above the
// first, and a k-th query walks the bits of k, jumping on each set bit.
// One transaction at a time: the next accept follows the result load, paced
// by dependent jump table reads; a result held by out_ready stalls the next.
// Reset empties the store.
// ----------------------------------------------------------------------------
module persistent_stack_level_ancestor_unit
  import psla_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [VERSION_W-1:0] in_version,
  input  wire logic [PVAL_W-1:0]    in_push_value,
  input  wire logic [KBITS-1:0]     in_ancestor_k,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [VERSION_W-1:0] out_result_version,
  output logic      [PVAL_W-1:0]    out_result_value,
  output logic      [DEPTH_W-1:0]   out_result_depth,
  output logic      [STATUS_W-1:0]  out_status
);

  // Command and status between sequencer and datapath
  psla_cmd_t  cmd;
  psla_stat_t stat;

  // Sequencer: accept one transaction, step the link build or walk, and
  // hold the finished result until the output register is free.
  psla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: depth, value and jump pointer stores plus the result register.
  psla_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_command),
    .in_version        (in_version),
    .in_push_value     (in_push_value),
    .in_ancestor_k     (in_ancestor_k),
    .out_result_version(out_result_version),
    .out_result_value  (out_result_value),
    .out_result_depth  (out_result_depth),
    .out_status        (out_status)
  );

`ifndef SYNTHESIS
  // One transaction in flight: the input side closes right after an accept.
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // An empty-stack result always reports depth zero.
  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_result_depth == '0))
    else $error("empty status with nonzero depth");

  // Any error result carries a zero value.
  a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_result_value == '0))
    else $error("error status with nonzero value");

  // A new result is loaded only while the sequencer is busy.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !in_ready)
    else $error("result loaded from the idle state");
`endif

endmodule
`default_nettype wire

// File: rtl/core/psla_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psla_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/psla_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psla_dp
// Datapath: node stores, jump pointer table, walk registers, result register.
// ----------------------------------------------------------------------------
module psla_dp
  import psla_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire psla_cmd_t            cmd,
  output psla_stat_t                stat,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [VERSION_W-1:0] in_version,
  input  wire logic [PVAL_W-1:0]    in_push_value,
  input  wire logic [KBITS-1:0]     in_ancestor_k,
  output logic      [VERSION_W-1:0] out_result_version,
  output logic      [PVAL_W-1:0]    out_result_value,
  output logic      [DEPTH_W-1:0]   out_result_depth,
  output logic      [STATUS_W-1:0]  out_status
);

  // Captured transaction
  cmd_t                  cmd_r;
  logic [VERSION_W-1:0]  ver_r;
  logic [NODE_W-1:0]     node_r;
  logic [VALUE_BITS-1:0] pval_r;
  logic [KBITS-1:0]      k_r;

  // Work registers
  logic [NODE_W-1:0] d_r;
  logic [NODE_W-1:0] n_r;
  logic [NODE_W-1:0] cur_r;
  logic [LVC_W-1:0]  lvl_r;
  logic [NODE_W-1:0] x_r;
  logic [KB_W-1:0]   b_r;
  logic [REP_W-1:0]  reps_r;
  logic [NF_W-1:0]   next_free_r;

  // Result register
  logic [VERSION_W-1:0] res_ver_r, res_ver_nxt;
  logic [PVAL_W-1:0]    res_val_r, res_val_nxt;
  logic [DEPTH_W-1:0]   res_depth_r, res_depth_nxt;
  status_t              res_st_r, res_st_nxt;

  // RAM ports
  logic                  dep_we, dep_re;
  logic [NODE_W-1:0]     dep_waddr, dep_raddr, dep_wdata, dep_rdata;
  logic                  val_we, val_re;
  logic [NODE_W-1:0]     val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;
  logic                  jt_we, jt_re;
  logic [JT_AW-1:0]      jt_waddr, jt_raddr;
  logic [NODE_W-1:0]     jt_wdata, jt_rdata;

  logic [NODE_W-1:0] d_now;
  logic [LVC_W-1:0]  lvl_prev;
  logic [KB_W-1:0]   b_inc;
  logic [NODE_W-1:0] load_node;

  assign d_now     = (node_r == '0) ? '0 : dep_rdata;
  assign lvl_prev  = lvl_r - LVC_W'(1);
  assign b_inc     = b_r + KB_W'(1);
  assign load_node = (NF_W'(in_version) < next_free_r) ? NODE_W'(in_version) : '0;

  psla_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_depth (
    .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .re(dep_re), .raddr(dep_raddr), .rdata(dep_rdata)
  );

  psla_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODES)) u_value (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .re(val_re), .raddr(val_raddr), .rdata(val_rdata)
  );

  psla_ram #(.WIDTH(NODE_W), .DEPTH(JT_DEPTH)) u_jump (
    .clk(clk), .we(jt_we), .waddr(jt_waddr), .wdata(jt_wdata),
    .re(jt_re), .raddr(jt_raddr), .rdata(jt_rdata)
  );

  always_comb begin
    dep_we    = cmd.push_start;
    dep_waddr = next_free_r[NODE_W-1:0];
    dep_wdata = d_now + NODE_W'(1);
    dep_re    = cmd.rd_node;
    dep_raddr = node_r;

    val_we    = cmd.push_start;
    val_waddr = next_free_r[NODE_W-1:0];
    val_wdata = pval_r;
    val_re    = cmd.rd_node | cmd.val_rd;
    val_raddr = cmd.rd_node ? node_r : x_r;

    jt_we    = cmd.push_start | cmd.link_zero | cmd.link_wr;
    jt_waddr = {n_r, lvl_r[LVL_W-1:0]};
    jt_wdata = cmd.link_wr ? jt_rdata : '0;
    if (cmd.push_start) begin
      jt_waddr = {next_free_r[NODE_W-1:0], LVL_W'(0)};
      jt_wdata = node_r;
    end
    jt_re    = cmd.rd_node | cmd.link_rd | cmd.walk_rd;
    jt_raddr = {node_r, LVL_W'(0)};
    if (cmd.link_rd) begin
      jt_raddr = {cur_r, lvl_prev[LVL_W-1:0]};
    end else if (cmd.walk_rd) begin
      jt_raddr = {x_r, walk_level(b_r)};
    end
  end

  // Result selection
  always_comb begin
    res_ver_nxt   = ver_r;
    res_val_nxt   = '0;
    res_depth_nxt = DEPTH_W'(d_now);
    res_st_nxt    = ST_OK;
    case (cmd.res_sel)
      RES_FULL:  res_st_nxt = ST_FULL;
      RES_EMPTY: begin
        res_depth_nxt = '0;
        res_st_nxt    = ST_EMPTY;
      end
      RES_POP: begin
        res_ver_nxt   = VERSION_W'(jt_rdata);
        res_depth_nxt = DEPTH_W'(d_now - NODE_W'(1));
      end
      RES_TOP:   res_val_nxt = PVAL_W'(val_rdata);
      RES_KBIG:  res_st_nxt = ST_KBIG;
      RES_PUSH: begin
        res_ver_nxt   = VERSION_W'(n_r);
        res_depth_nxt = DEPTH_W'(d_r + NODE_W'(1));
      end
      RES_KTH: begin
        res_val_nxt   = PVAL_W'(val_rdata);
        res_depth_nxt = DEPTH_W'(d_r);
      end
      default: res_st_nxt = ST_OK;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= NF_W'(1);
    end else if (cmd.push_start) begin
      next_free_r <= next_free_r + NF_W'(1);
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= cmd_t'(in_command);
      ver_r  <= in_version;
      node_r <= load_node;
      pval_r <= VALUE_BITS'(in_push_value);
      k_r    <= in_ancestor_k;
    end
    if (cmd.chk) begin
      d_r <= d_now;
    end
    if (cmd.push_start) begin
      n_r   <= next_free_r[NODE_W-1:0];
      cur_r <= node_r;
      lvl_r <= LVC_W'(1);
    end
    if (cmd.link_zero) begin
      lvl_r <= lvl_r + LVC_W'(1);
    end
    if (cmd.link_wr) begin
      cur_r <= jt_rdata;
      lvl_r <= lvl_r + LVC_W'(1);
    end
    if (cmd.walk_start) begin
      x_r    <= node_r;
      b_r    <= '0;
      reps_r <= rep_of('0);
    end
    if (cmd.walk_skip) begin
      b_r    <= b_inc;
      reps_r <= rep_of(b_inc);
    end
    if (cmd.walk_step) begin
      x_r <= jt_rdata;
      if (reps_r == REP_W'(1)) begin
        b_r    <= b_inc;
        reps_r <= rep_of(b_inc);
      end else begin
        reps_r <= reps_r - REP_W'(1);
      end
    end
    if (cmd.res_load) begin
      res_ver_r   <= res_ver_nxt;
      res_val_r   <= res_val_nxt;
      res_depth_r <= res_depth_nxt;
      res_st_r    <= res_st_nxt;
    end
  end

  always_comb begin
    stat.command    = cmd_r;
    stat.full       = (next_free_r == NF_W'(NODES));
    stat.depth_zero = (d_now == '0);
    stat.k_big      = (CMP_W'(k_r) >= CMP_W'(d_now));
    stat.link_done  = (lvl_r == LVC_W'(LEVELS));
    stat.mid_zero   = (cur_r == '0);
    stat.bit_end    = (b_r == KB_W'(KBITS));
    stat.bit_set    = (b_r < KB_W'(KBITS)) && k_r[b_r[KI_W-1:0]];
  end

  assign out_result_version = res_ver_r;
  assign out_result_value   = res_val_r;
  assign out_result_depth   = res_depth_r;
  assign out_status         = res_st_r;

endmodule
`default_nettype wire

// File: rtl/core/psla_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psla_ctrl
// Sequencer for push link building, k-th walks and the result handshake.
// ----------------------------------------------------------------------------
module psla_ctrl
  import psla_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire psla_stat_t stat,
  output psla_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_sel = RES_FULL;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_node = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        cmd.chk = 1'b1;
        case (stat.command)
          CMD_PUSH: begin
            if (!stat.full) begin
              cmd.push_start = 1'b1;
              state_nxt      = S_LINK;
            end else if (out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_FULL;
              state_nxt    = S_IDLE;
            end
          end
          CMD_POP, CMD_TOP: begin
            if (out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = stat.depth_zero ? RES_EMPTY :
                             (stat.command == CMD_POP) ? RES_POP : RES_TOP;
              state_nxt    = S_IDLE;
            end
          end
          CMD_KTH: begin
            if (!stat.depth_zero && !stat.k_big) begin
              cmd.walk_start = 1'b1;
              state_nxt      = S_WALK;
            end else if (out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = stat.depth_zero ? RES_EMPTY : RES_KBIG;
              state_nxt    = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LINK: begin
        if (stat.link_done) begin
          if (out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_PUSH;
            state_nxt    = S_IDLE;
          end
        end else if (stat.mid_zero) begin
          cmd.link_zero = 1'b1;
        end else begin
          cmd.link_rd = 1'b1;
          state_nxt   = S_LINK_WAIT;
        end
      end
      S_LINK_WAIT: begin
        cmd.link_wr = 1'b1;
        state_nxt   = S_LINK;
      end
      S_WALK: begin
        if (stat.bit_end) begin
          cmd.val_rd = 1'b1;
          state_nxt  = S_VALUE;
        end else if (!stat.bit_set) begin
          cmd.walk_skip = 1'b1;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        cmd.walk_step = 1'b1;
        state_nxt     = S_WALK;
      end
      S_VALUE: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_KTH;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: dv/tb_persistent_stack_level_ancestor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_persistent_stack_level_ancestor_unit
// Self-checking bench for the persistent stack level ancestor unit. A clocked
// driver feeds push, pop, top and k-th transactions from a queue of pending
// operations. On every accepted transaction a local binary-lifting model of
// the node store predicts the result. A clocked monitor compares each
// returned result field by field with the oldest prediction. Both sides idle
// at random, the receiver holds off once for a long stretch, and most
// random operations are pushes that grow the store.
// ----------------------------------------------------------------------------
module tb_persistent_stack_level_ancestor_unit;
  import psla_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES   = 60;    // settle time after the last result
  localparam int LONG_HOLD      = 400;   // receiver hold-off that backs up the block
  localparam int HOLD_AT_RESULT = 600;   // result count that triggers the hold-off
  localparam int RANDOM_OPS     = 930;   // random operations after the directed ones

  // One stack operation as offered on the input channel
  typedef struct packed {
    cmd_t                 cmd;
    logic [VERSION_W-1:0] ver;
    logic [PVAL_W-1:0]    pval;
    logic [KBITS-1:0]     k;
    logic                 wait_drain;  // hold this one until nothing is in flight
  } stack_op_t;

  // One result as returned on the output channel
  typedef struct packed {
    logic [VERSION_W-1:0] ver;
    logic [PVAL_W-1:0]    val;
    logic [DEPTH_W-1:0]   depth;
    status_t              st;
  } stack_res_t;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command    = '0;
  logic [VERSION_W-1:0] in_version    = '0;
  logic [PVAL_W-1:0]    in_push_value = '0;
  logic [KBITS-1:0]     in_ancestor_k = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [VERSION_W-1:0] out_result_version;
  logic [PVAL_W-1:0]    out_result_value;
  logic [DEPTH_W-1:0]   out_result_depth;
  logic [STATUS_W-1:0]  out_status;

  persistent_stack_level_ancestor_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_version         (in_version),
    .in_push_value      (in_push_value),
    .in_ancestor_k      (in_ancestor_k),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_version (out_result_version),
    .out_result_value   (out_result_value),
    .out_result_depth   (out_result_depth),
    .out_status         (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  stack_op_t  pending_ops[$];
  stack_res_t expected_results[$];
  int         fault_count = 0;

  // --------------------------------------------------------------------------
  // Node store model: jump pointers, values, depths and the allocation point
  // --------------------------------------------------------------------------
  logic [NODE_W-1:0] jump_ptr   [NODES][LEVELS];
  logic [PVAL_W-1:0] node_val   [NODES];
  int                node_dep   [NODES];
  int                free_node  = 1;

  // Predict one result and advance the store model.
  function automatic stack_res_t predict_stack_op(input stack_op_t op);
    stack_res_t r;
    int         node;
    int         d;
    int         n;
    int         mid;
    int         x;
    int         reps;
    // A version that was never allocated stands for the empty root
    node    = (int'(op.ver) < free_node) ? int'(op.ver) : 0;
    d       = node_dep[node];
    r.ver   = op.ver;
    r.val   = '0;
    r.depth = DEPTH_W'(d);
    r.st    = ST_OK;
    case (op.cmd)
      CMD_PUSH: begin
        if (free_node >= NODES) begin
          r.st = ST_FULL;
        end else begin
          n             = free_node;
          free_node     = free_node + 1;
          node_val[n]   = op.pval;
          node_dep[n]   = d + 1;
          jump_ptr[n][0] = NODE_W'(node);
          // Each level doubles the previous one; stop at the root
          for (int i = 1; i < LEVELS; i++) begin
            mid = int'(jump_ptr[n][i-1]);
            jump_ptr[n][i] = (mid == 0) ? '0 : jump_ptr[mid][i-1];
          end
          r.ver   = VERSION_W'(n);
          r.depth = DEPTH_W'(d + 1);
        end
      end
      CMD_POP: begin
        if (d == 0) begin
          r.st    = ST_EMPTY;
          r.depth = '0;
        end else begin
          r.ver   = VERSION_W'(jump_ptr[node][0]);
          r.depth = DEPTH_W'(d - 1);
        end
      end
      CMD_TOP: begin
        if (d == 0) begin
          r.st    = ST_EMPTY;
          r.depth = '0;
        end else begin
          r.val = node_val[node];
        end
      end
      default: begin
        // Empty check comes ahead of the k range check
        if (d == 0) begin
          r.st    = ST_EMPTY;
          r.depth = '0;
        end else if (int'(op.k) >= d) begin
          r.st = ST_KBIG;
        end else begin
          x = node;
          for (int b = 0; b < KBITS; b++) begin
            if (op.k[b]) begin
              if (b < LEVELS) begin
                x = int'(jump_ptr[x][b]);
              end else begin
                // Bits past the top level walk as repeated top-level jumps
                reps = 1 << (b - LEVELS + 1);
                for (int j = 0; j < reps; j++) begin
                  x = int'(jump_ptr[x][LEVELS-1]);
                end
              end
            end
          end
          r.val = node_val[x];
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer pending operations, predict each accepted transaction
  // --------------------------------------------------------------------------
  stack_op_t cur_op;
  logic      offering;
  int        send_gap     = 0;
  int        accepted_ops = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_stack_op(cur_op));
        offering = 1'b0;
        // Alternate stretches of back-to-back traffic with random gaps
        send_gap = ((accepted_ops % 90) < 30) ? 0 : $urandom_range(0, 14);
        accepted_ops++;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].wait_drain && expected_results.size() > 0)) begin
          cur_op        = pending_ops.pop_front();
          in_command    <= cur_op.cmd;
          in_version    <= cur_op.ver;
          in_push_value <= cur_op.pval;
          in_ancestor_k <= cur_op.k;
          offering      = 1'b1;
        end
      end
      // One assignment per edge keeps valid steady across back-to-back items
      in_valid <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take results, compare with the oldest prediction
  // --------------------------------------------------------------------------
  stack_res_t got_res;
  stack_res_t want_res;
  logic       take;
  int         recv_gap     = 0;
  int         recv_hold    = 0;
  int         results_seen = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_res.ver   = out_result_version;
        got_res.val   = out_result_value;
        got_res.depth = out_result_depth;
        got_res.st    = status_t'(out_status);
        if (expected_results.size() == 0) begin
          if (fault_count < 10) begin
            $display("unexpected result: ver=%0d val=%0d depth=%0d status=%0d",
                     got_res.ver, got_res.val, got_res.depth, got_res.st);
          end
          fault_count++;
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.ver !== want_res.ver || got_res.val !== want_res.val ||
              got_res.depth !== want_res.depth || got_res.st !== want_res.st) begin
            if (fault_count < 10) begin
              $display("mismatch at result %0d: exp ver=%0d val=%0d depth=%0d status=%0d",
                       results_seen, want_res.ver, want_res.val, want_res.depth,
                       want_res.st);
              $display("                         got ver=%0d val=%0d depth=%0d status=%0d",
                       got_res.ver, got_res.val, got_res.depth, got_res.st);
            end
            fault_count++;
          end
        end
        results_seen++;
        recv_gap = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 14);
        // Hold off long enough for the block to fill and stall its input
        if (results_seen == HOLD_AT_RESULT) begin
          recv_hold = LONG_HOLD;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        take = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_ready <= take;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transaction moves for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: shadow of allocation, used only to steer versions and k
  // --------------------------------------------------------------------------
  int   gen_next = 1;
  int   gen_cur  = 0;
  int   gen_depth  [NODES];
  int   gen_parent [NODES];
  logic hold_next  = 1'b0;

  // Queue one operation; follow the working chain when it is the target.
  task automatic add_op(input cmd_t c, input int v, input int pv, input int k);
    stack_op_t op;
    int        node;
    op.cmd        = c;
    op.ver        = VERSION_W'(v);
    op.pval       = PVAL_W'(pv);
    op.k          = KBITS'(k);
    op.wait_drain = hold_next;
    hold_next     = 1'b0;
    pending_ops.push_back(op);
    node = (v < gen_next) ? v : 0;
    if (c == CMD_PUSH && gen_next < NODES) begin
      gen_depth[gen_next]  = gen_depth[node] + 1;
      gen_parent[gen_next] = node;
      if (node == gen_cur) begin
        gen_cur = gen_next;
      end
      gen_next++;
    end else if (c == CMD_POP && gen_depth[node] > 0 && node == gen_cur) begin
      gen_cur = gen_parent[node];
    end
  endtask

  int   sel;
  int   v;
  int   node;
  int   d;
  int   k;
  int   rnd_ops   = 0;
  cmd_t c;

  initial begin
    // Clear the model so that nothing starts out unknown
    for (int n = 0; n < NODES; n++) begin
      node_val[n]   = '0;
      node_dep[n]   = 0;
      gen_depth[n]  = 0;
      gen_parent[n] = 0;
      for (int l = 0; l < LEVELS; l++) begin
        jump_ptr[n][l] = '0;
      end
    end

    // Directed: empty store first, then a short chain and a branch
    add_op(CMD_TOP,  0, 255, 0);
    add_op(CMD_POP,  0, 0, 1023);
    add_op(CMD_KTH,  0, 0, 0);
    add_op(CMD_KTH,  0, 0, 1023);      // empty wins over k too large
    add_op(CMD_PUSH, 0, 0, 0);         // node 1
    add_op(CMD_PUSH, 1, 255, 1023);    // node 2
    add_op(CMD_PUSH, 2, 8'hA5, 0);     // node 3
    add_op(CMD_TOP,  3, 0, 0);
    add_op(CMD_KTH,  3, 0, 0);         // k of zero gives the top itself
    add_op(CMD_KTH,  3, 0, 2);
    add_op(CMD_KTH,  3, 0, 3);         // k equal to depth reports k too large
    add_op(CMD_KTH,  3, 0, 1023);
    add_op(CMD_POP,  3, 0, 0);
    add_op(CMD_POP,  1, 0, 0);
    add_op(CMD_TOP,  1000, 0, 0);      // unallocated version reads as empty
    add_op(CMD_PUSH, 1023, 8'h5A, 0);  // unallocated version pushes onto the root
    add_op(CMD_POP,  1023, 0, 0);
    add_op(CMD_PUSH, 2, 8'h3C, 0);     // branch off an older version
    add_op(CMD_KTH,  5, 0, 1);
    add_op(CMD_KTH,  1023, 0, 0);

    // Random: mostly pushes that grow the store, mixed with queries
    hold_next = 1'b1;
    while (rnd_ops < RANDOM_OPS) begin
      if (rnd_ops == 500) begin
        hold_next = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        v = gen_cur;
      end else if (sel < 75) begin
        v = $urandom_range(0, gen_next - 1);
      end else if (sel < 85) begin
        v = $urandom_range(0, 1023);
      end else if (sel < 92) begin
        v = 0;
      end else begin
        v = gen_next - 1;
      end
      node = (v < gen_next) ? v : 0;
      d    = gen_depth[node];
      sel  = $urandom_range(0, 99);
      if (sel < 75) begin
        c = CMD_PUSH;
      end else if (sel < 82) begin
        c = CMD_POP;
      end else if (sel < 88) begin
        c = CMD_TOP;
      end else begin
        c = CMD_KTH;
      end
      sel = $urandom_range(0, 99);
      if (d > 0 && sel < 60) begin
        k = $urandom_range(0, d - 1);
      end else if (sel < 70) begin
        k = d;
      end else if (sel < 80) begin
        k = (d > 0) ? d - 1 : 0;
      end else if (sel < 90) begin
        k = 0;
      end else begin
        k = $urandom_range(0, 1023);
      end
      add_op(c, v, $urandom_range(0, 255), k);
      rnd_ops++;
    end

    // Wait for every item to go out and every result to come back
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    fault_count += expected_results.size();
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/psla_pkg.sv
rtl/core/psla_ram.sv
rtl/core/psla_dp.sv
rtl/core/psla_ctrl.sv
rtl/core/persistent_stack_level_ancestor_unit.sv
dv/tb_persistent_stack_level_ancestor_unit.sv
